### rtl/core/text_console_glyph_renderer_unit_macros.svh
// assertion macros used by the glyph renderer sequencer
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_UNIT_MACROS_SVH

// condition holds at every edge out of reset
`define TCGR_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("tcgr check failed");

// consequent holds in the same cycle as the antecedent
`define TCGR_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcgr check failed");

// consequent holds in the cycle after the antecedent
`define TCGR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcgr check failed");

`endif

### rtl/core/tcgr_pkg.sv
// shared types and constants of the glyph renderer
package tcgr_pkg;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 288;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [12:0] GLYPH_WIDTH  = 13'd8;

  localparam logic [23:0] FG_RESET     = 24'h808080;
  localparam logic [23:0] BG_RESET     = 24'h000000;
  localparam logic [12:0] WIDTH_RESET  = 13'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;
  localparam logic [13:0] PITCH_RESET  = 14'd640;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_ROW,
    ST_CLEAR
  } st_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE    = 3'd0,
    REG_FG_COLOR  = 3'd1,
    REG_BG_COLOR  = 3'd2,
    REG_WIDTH     = 3'd3,
    REG_HEIGHT    = 3'd4,
    REG_ROW_PITCH = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic        enable;
    logic [23:0] fg_color;
    logic [23:0] bg_color;
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [13:0] row_pitch_words;
  } cfg_t;

endpackage

### rtl/core/text_console_glyph_renderer_unit.sv
// Text console glyph renderer: draws 8-pixel-wide glyphs into framebuffer row words.
// in_*: one word per command. tuser = cmd (0 put character, 1 load font row),
//   tdata = char_code, glyph_row, font_bits; tlast marks a string end and is ignored.
// out_*: one word per framebuffer action. tuser = kind (0 row write, 1 clear),
//   tdata = pixel_index, pixel_0..pixel_7; tlast flags the final word of a command.
// cfg_*: register writes (index, data), always ready; write only while idle.
// A font load or a newline without clear stays in ST_IDLE; one that clears adds ST_CLEAR.
// A character goes through ST_READ and ST_ROW with one row word per cycle while the
// output is not stalled, plus ST_CLEAR when the cursor wrap clears the screen. The pace
// is set by the single font store read port and the one shared index multiply-add.
// in_tready is high only between commands; a new command is taken while the last
// word of the previous one still waits in the output register.
// With out_tready low on a valid word the sequencer holds its row and the font read address.
// Reset clears the cursor, the sequencer and the output valid, and loads the register
// defaults; the font store is not cleared and must be loaded before use.
module text_console_glyph_renderer_unit
  import tcgr_pkg::*;
#(
  parameter int GLYPH_HEIGHT = 16,
  parameter int GLYPH_COUNT  = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // char_code[7:0], glyph_row[11:8], font_bits[19:12]
  input  logic                   in_tuser,   // cmd
  input  logic                   in_tlast,   // string_end
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // pixel_index[24:0], pixel_0..pixel_7 32 bits each
  output logic                   out_tuser,  // kind
  output logic                   out_tlast,  // last
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int ADDR_W = $clog2(GLYPH_COUNT * GLYPH_HEIGHT);

  cfg_t              cfg_r, cfg_nxt;
  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
  logic [7:0]        ram_wr_data, ram_rd_data;
  logic              string_end_unused;

  assign cfg_ready         = 1'b1;
  assign string_end_unused = in_tlast;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_ENABLE:    cfg_nxt.enable          = cfg_data[0];
        REG_FG_COLOR:  cfg_nxt.fg_color        = cfg_data;
        REG_BG_COLOR:  cfg_nxt.bg_color        = cfg_data;
        REG_WIDTH:     cfg_nxt.screen_width    = cfg_data[12:0];
        REG_HEIGHT:    cfg_nxt.screen_height   = cfg_data[12:0];
        REG_ROW_PITCH: cfg_nxt.row_pitch_words = cfg_data[13:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable          <= 1'b0;
      cfg_r.fg_color        <= FG_RESET;
      cfg_r.bg_color        <= BG_RESET;
      cfg_r.screen_width    <= WIDTH_RESET;
      cfg_r.screen_height   <= HEIGHT_RESET;
      cfg_r.row_pitch_words <= PITCH_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tcgr_ram #(
    .WIDTH(8),
    .DEPTH(GLYPH_COUNT * GLYPH_HEIGHT)
  ) u_font (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  tcgr_seq #(
    .GLYPH_HEIGHT(GLYPH_HEIGHT),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .ram_wr_en  (ram_wr_en),
    .ram_wr_addr(ram_wr_addr),
    .ram_wr_data(ram_wr_data),
    .ram_rd_addr(ram_rd_addr),
    .ram_rd_data(ram_rd_data)
  );

endmodule

### rtl/core/tcgr_ram.sv
// simple dual-port ram with registered read
module tcgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/tcgr_idx_unit.sv
// shared multiply-add unit for the framebuffer word index of one glyph row
module tcgr_idx_unit #(
  parameter int ROW_W = 4
) (
  input  logic [12:0]      cursor_x,
  input  logic [12:0]      cursor_y,
  input  logic [ROW_W-1:0] row,
  input  logic [13:0]      pitch,
  output logic [24:0]      pixel_index
);

  logic [13:0] y_sum;
  logic [27:0] prod;

  assign y_sum       = {1'b0, cursor_y} + 14'(row);
  assign prod        = 28'(y_sum) * 28'(pitch);
  assign pixel_index = prod[24:0] + 25'(cursor_x);

endmodule

### rtl/core/tcgr_seq.sv
// sequencer: cursor state, font store access and output word register
module tcgr_seq
  import tcgr_pkg::*;
#(
  parameter int GLYPH_HEIGHT = 16,
  parameter int GLYPH_COUNT  = 256,
  localparam int ADDR_W      = $clog2(GLYPH_COUNT * GLYPH_HEIGHT)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast,
  output logic                   ram_wr_en,
  output logic [ADDR_W-1:0]      ram_wr_addr,
  output logic [7:0]             ram_wr_data,
  output logic [ADDR_W-1:0]      ram_rd_addr,
  input  logic [7:0]             ram_rd_data
);

  `include "text_console_glyph_renderer_unit_macros.svh"

  localparam int ROW_W = $clog2(GLYPH_HEIGHT);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_HEIGHT - 1);
  localparam logic [12:0] GH13 = 13'(GLYPH_HEIGHT);

  st_t               state_r, state_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [12:0]       cursor_x_r, cursor_x_nxt;
  logic [12:0]       cursor_y_r, cursor_y_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic              out_last_r, out_last_nxt;
  logic [24:0]       out_idx_r, out_idx_nxt;
  logic [31:0]       out_px_r [8];
  logic [31:0]       out_px_nxt [8];

  logic        accept, is_load, is_put, is_newline, load_ok;
  logic [7:0]  code, font_bits, glyph_sel;
  logic [3:0]  glyph_row;
  logic        out_free, row_done, wrap_x, clear_y, load_row, load_clr;
  logic [12:0] cx_plus, cy_plus, sw_lim, sh_lim;
  logic [24:0] unit_idx;
  logic [ROW_W-1:0] rd_row;
  logic [31:0] fill_word;

  assign code      = in_tdata[7:0];
  assign glyph_row = in_tdata[11:8];
  assign font_bits = in_tdata[19:12];

  assign accept     = in_tvalid && in_tready;
  assign is_load    = accept && in_tuser;
  assign is_put     = accept && !in_tuser && cfg.enable;
  assign is_newline = code == NEWLINE_CODE;
  assign load_ok    = (32'(code) < GLYPH_COUNT) && (32'(glyph_row) < GLYPH_HEIGHT);
  assign glyph_sel  = (32'(code) >= GLYPH_COUNT) ? code - 8'(GLYPH_COUNT) : code;

  assign out_free = !out_valid_r || out_tready;
  assign row_done = row_r == ROW_LAST;
  assign cx_plus  = cursor_x_r + GLYPH_WIDTH;
  assign cy_plus  = cursor_y_r + GH13;
  assign sw_lim   = (cfg.screen_width >= GLYPH_WIDTH) ? cfg.screen_width - GLYPH_WIDTH : 13'd0;
  assign sh_lim   = (cfg.screen_height >= GH13) ? cfg.screen_height - GH13 : 13'd0;
  assign wrap_x   = cx_plus >= sw_lim;
  assign clear_y  = cy_plus >= sh_lim;
  assign fill_word = {4{cfg.bg_color[7:0]}};

  tcgr_idx_unit #(
    .ROW_W(ROW_W)
  ) u_idx (
    .cursor_x   (cursor_x_r),
    .cursor_y   (cursor_y_r),
    .row        (row_r),
    .pitch      (cfg.row_pitch_words),
    .pixel_index(unit_idx)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (is_put) begin
          if (is_newline) begin
            state_nxt = clear_y ? ST_CLEAR : ST_IDLE;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_ROW;
      end
      ST_ROW: begin
        if (out_free && row_done) begin
          state_nxt = (wrap_x && clear_y) ? ST_CLEAR : ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready   = state_r == ST_IDLE;
    load_row    = (state_r == ST_ROW) && out_free;
    load_clr    = (state_r == ST_CLEAR) && out_free;
    rd_row      = (load_row && !row_done) ? row_r + 1'b1 : row_r;
    ram_wr_en   = is_load && load_ok;
    ram_wr_addr = ADDR_W'(32'(code) * GLYPH_HEIGHT + 32'(glyph_row));
    ram_wr_data = font_bits;
    ram_rd_addr = base_r + ADDR_W'(rd_row);
  end

  // datapath
  always_comb begin
    row_nxt       = row_r;
    base_nxt      = base_r;
    cursor_x_nxt  = cursor_x_r;
    cursor_y_nxt  = cursor_y_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    out_idx_nxt   = out_idx_r;
    for (int j = 0; j < 8; j++) begin
      out_px_nxt[j] = out_px_r[j];
    end
    if (is_put) begin
      row_nxt  = '0;
      base_nxt = ADDR_W'(32'(glyph_sel) * GLYPH_HEIGHT);
      if (is_newline) begin
        cursor_x_nxt = '0;
        cursor_y_nxt = clear_y ? 13'd0 : cy_plus;
      end
    end
    if (load_row) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = 1'b0;
      out_last_nxt  = row_done && !(wrap_x && clear_y);
      out_idx_nxt   = unit_idx;
      for (int j = 0; j < 8; j++) begin
        out_px_nxt[j] = ram_rd_data[7-j] ? {8'h00, cfg.fg_color} : {8'h00, cfg.bg_color};
      end
      if (row_done) begin
        if (wrap_x) begin
          cursor_x_nxt = '0;
          cursor_y_nxt = clear_y ? 13'd0 : cy_plus;
        end else begin
          cursor_x_nxt = cx_plus;
        end
      end else begin
        row_nxt = row_r + 1'b1;
      end
    end
    if (load_clr) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = 1'b1;
      out_last_nxt  = 1'b1;
      out_idx_nxt   = '0;
      for (int j = 0; j < 8; j++) begin
        out_px_nxt[j] = fill_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_x_r  <= cursor_x_nxt;
      cursor_y_r  <= cursor_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    base_r     <= base_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
    out_idx_r  <= out_idx_nxt;
    for (int j = 0; j < 8; j++) begin
      out_px_r[j] <= out_px_nxt[j];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'b0, out_px_r[7], out_px_r[6], out_px_r[5], out_px_r[4],
                       out_px_r[3], out_px_r[2], out_px_r[1], out_px_r[0], out_idx_r};

  `TCGR_ASSERT_ALWAYS(a_cursor_x_aligned, cursor_x_r[2:0] == 3'd0)
  `TCGR_ASSERT_IMPLY(a_clear_home, state_r == ST_CLEAR, cursor_x_r == 13'd0 && cursor_y_r == 13'd0)
  `TCGR_ASSERT_NEXT(a_row_end_last, state_r == ST_ROW && state_nxt == ST_IDLE,
                    out_valid_r && out_last_r && !out_kind_r)
  `TCGR_ASSERT_NEXT(a_clear_word, state_r == ST_CLEAR && state_nxt == ST_IDLE,
                    out_valid_r && out_last_r && out_kind_r)

endmodule

### test/text_console_glyph_renderer_unit_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the glyph renderer: directed table, then randomized phases
module text_console_glyph_renderer_unit_test;
  import tcgr_pkg::*;

  localparam int GLYPH_ROWS     = 16;
  localparam int GLYPH_TOTAL    = 256;
  localparam logic CMD_PUT      = 1'b0;
  localparam logic CMD_LOAD     = 1'b1;
  localparam logic KIND_ROW     = 1'b0;
  localparam logic KIND_CLEAR   = 1'b1;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 10;
  localparam int PRELOAD_COUNT  = 4;
  localparam logic [PRELOAD_COUNT-1:0][7:0] PRELOAD_CODES =
    {8'h00, 8'hFF, 8'h55, 8'hAA};

  typedef struct packed {
    logic             kind;
    logic [24:0]      index;
    logic [7:0][31:0] px;
    logic             last;
  } fb_word_t;

  typedef enum logic {
    STEP_CFG,
    STEP_CMD
  } step_t;

  typedef struct packed {
    step_t       what;
    cfg_reg_t    reg_sel;
    logic [23:0] value;
    logic        cmd;
    logic [7:0]  code;
    logic [3:0]  glyph_row;
    logic [7:0]  bits;
    logic        string_end;
    logic        typed;
    logic        typed_clear;
    logic [31:0] typed_fill;
  } script_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  cfg_t        shadow_cfg;
  logic [12:0] cur_x;
  logic [12:0] cur_y;
  logic [7:0]  glyph_rows [GLYPH_TOTAL*GLYPH_ROWS];
  bit          row_loaded [GLYPH_TOTAL*GLYPH_ROWS];
  bit          glyph_drawable [GLYPH_TOTAL];
  logic [7:0]  drawable_codes [$];
  fb_word_t    pending_fb_words [$];
  script_row_t script [$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          ready_hold = 0;
  bit          calm_phase = 1'b0;
  bit          busy_since_cfg = 1'b0;

  always #5 clk = ~clk;

  text_console_glyph_renderer_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm_phase || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [23:0] pick_span(int lo, int hi, int mid_hi);
    int roll;
    roll = $urandom_range(0, 5);
    if (roll == 0) return 24'(lo);
    if (roll == 1) return 24'(hi);
    return 24'($urandom_range(lo, mid_hi));
  endfunction

  function automatic int floor_sub(int a, int b);
    return (a >= b) ? a - b : 0;
  endfunction

  function automatic script_row_t cfg_row(cfg_reg_t sel, logic [23:0] data);
    script_row_t s;
    s = '0;
    s.what = STEP_CFG;
    s.reg_sel = sel;
    s.value = data;
    return s;
  endfunction

  function automatic script_row_t cmd_row(logic cmd, logic [7:0] code, logic [3:0] glyph_row,
                                          logic [7:0] bits, logic string_end, logic typed,
                                          logic typed_clear, logic [31:0] typed_fill);
    script_row_t s;
    s = '0;
    s.what = STEP_CMD;
    s.cmd = cmd;
    s.code = code;
    s.glyph_row = glyph_row;
    s.bits = bits;
    s.string_end = string_end;
    s.typed = typed;
    s.typed_clear = typed_clear;
    s.typed_fill = typed_fill;
    return s;
  endfunction

  task automatic check_field(input string name, input logic [31:0] expv, input logic [31:0] actv);
    if (actv !== expv) begin
      $display("%0t: %s expected %h actual %h", $time, name, expv, actv);
      mismatch_count++;
    end
  endtask

  // newline: home column, next text line, clear once past the bottom
  task automatic line_feed(ref fb_word_t batch[$]);
    fb_word_t w;
    cur_x = '0;
    cur_y = cur_y + 13'(GLYPH_ROWS);
    if (int'(cur_y) >= floor_sub(int'(shadow_cfg.screen_height), GLYPH_ROWS)) begin
      w.kind = KIND_CLEAR;
      w.index = '0;
      w.px = {32{shadow_cfg.bg_color[7:0]}};
      w.last = 1'b0;
      batch.push_back(w);
      cur_x = '0;
      cur_y = '0;
    end
  endtask

  task automatic render_command(input logic cmd, input logic [7:0] code,
                                input logic [3:0] glyph_row, input logic [7:0] bits,
                                ref fb_word_t batch[$]);
    fb_word_t    w;
    logic [7:0]  fb;
    logic [31:0] idx;
    bit          all_rows;
    batch.delete();
    if (cmd == CMD_LOAD) begin
      glyph_rows[{code, glyph_row}] = bits;
      row_loaded[{code, glyph_row}] = 1'b1;
      all_rows = 1'b1;
      for (int r = 0; r < GLYPH_ROWS; r++) all_rows &= row_loaded[{code, 4'(r)}];
      if (all_rows && !glyph_drawable[code]) begin
        glyph_drawable[code] = 1'b1;
        drawable_codes.push_back(code);
      end
      return;
    end
    if (!shadow_cfg.enable) return;
    if (code == NEWLINE_CODE) begin
      line_feed(batch);
    end else begin
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        fb = glyph_rows[{code, 4'(r)}];
        idx = 32'(cur_x) + (32'(cur_y) + 32'(r)) * 32'(shadow_cfg.row_pitch_words);
        w.kind = KIND_ROW;
        w.index = idx[24:0];
        w.last = 1'b0;
        for (int j = 0; j < 8; j++) begin
          w.px[j] = fb[7 - j] ? {8'h00, shadow_cfg.fg_color} : {8'h00, shadow_cfg.bg_color};
        end
        batch.push_back(w);
      end
      cur_x = cur_x + GLYPH_WIDTH;
      if (int'(cur_x) >= floor_sub(int'(shadow_cfg.screen_width), int'(GLYPH_WIDTH))) begin
        line_feed(batch);
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
  endtask

  task automatic pause_input(input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    while (pending_fb_words.size() != 0) @(posedge clk);
  endtask

  // returns at the edge that accepts the word
  task automatic drive_command(input logic cmd, input logic [7:0] code,
                               input logic [3:0] glyph_row, input logic [7:0] bits,
                               input logic string_end);
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tlast <= string_end;
    in_tdata <= {4'b0000, bits, glyph_row, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    busy_since_cfg = 1'b1;
  endtask

  task automatic issue_command(input logic cmd, input logic [7:0] code,
                               input logic [3:0] glyph_row, input logic [7:0] bits,
                               input logic string_end, input logic typed,
                               input logic typed_clear, input logic [31:0] typed_fill);
    fb_word_t batch [$];
    fb_word_t w;
    drive_command(cmd, code, glyph_row, bits, string_end);
    render_command(cmd, code, glyph_row, bits, batch);
    if (typed) begin
      batch.delete();
      if (typed_clear) begin
        w.kind = KIND_CLEAR;
        w.index = '0;
        w.px = {8{typed_fill}};
        w.last = 1'b1;
        batch.push_back(w);
      end
    end
    foreach (batch[i]) pending_fb_words.push_back(batch[i]);
    pause_input(pick_gap());
  endtask

  task automatic write_register(input cfg_reg_t sel, input logic [23:0] data);
    if (busy_since_cfg) begin
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
      busy_since_cfg = 1'b0;
    end
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (sel)
      REG_ENABLE:    shadow_cfg.enable = data[0];
      REG_FG_COLOR:  shadow_cfg.fg_color = data;
      REG_BG_COLOR:  shadow_cfg.bg_color = data;
      REG_WIDTH:     shadow_cfg.screen_width = data[12:0];
      REG_HEIGHT:    shadow_cfg.screen_height = data[12:0];
      REG_ROW_PITCH: shadow_cfg.row_pitch_words = data[13:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!calm_phase && $urandom_range(0, 3) == 0) ready_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin : out_check
    fb_word_t exp_w;
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_tvalid && out_tready) begin
        if (pending_fb_words.size() == 0) begin
          $display("%0t: unexpected word expected none actual kind %0h index %h",
                   $time, out_tuser, out_tdata[24:0]);
          mismatch_count++;
        end else begin
          exp_w = pending_fb_words.pop_front();
          check_field("kind", 32'(exp_w.kind), 32'(out_tuser));
          check_field("pixel_index", 32'(exp_w.index), 32'(out_tdata[24:0]));
          for (int j = 0; j < 8; j++) begin
            check_field($sformatf("pixel_%0d", j), exp_w.px[j], out_tdata[25 + 32*j +: 32]);
          end
          check_field("last", 32'(exp_w.last), 32'(out_tlast));
        end
      end
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int         roll;
    logic [7:0] code;
    shadow_cfg = '{enable: 1'b0, fg_color: FG_RESET, bg_color: BG_RESET,
                   screen_width: WIDTH_RESET, screen_height: HEIGHT_RESET,
                   row_pitch_words: PITCH_RESET};
    cur_x = '0;
    cur_y = '0;

    // disabled console, both commands
    script.push_back(cmd_row(CMD_PUT, 8'h41, 4'd0, 8'h00, 1'b0, 1'b1, 1'b0, 32'h0));
    script.push_back(cmd_row(CMD_PUT, NEWLINE_CODE, 4'd0, 8'h00, 1'b0, 1'b1, 1'b0, 32'h0));
    script.push_back(cmd_row(CMD_LOAD, 8'h00, 4'd0, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0));
    script.push_back(cmd_row(CMD_LOAD, 8'hFF, 4'd15, 8'hFF, 1'b1, 1'b0, 1'b0, 32'h0));
    script.push_back(cfg_row(REG_ENABLE, 24'd1));
    script.push_back(cmd_row(CMD_PUT, 8'h00, 4'd0, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0));
    script.push_back(cmd_row(CMD_PUT, 8'hFF, 4'd15, 8'hFF, 1'b1, 1'b0, 1'b0, 32'h0));
    // minimum height: every newline clears
    script.push_back(cfg_row(REG_HEIGHT, 24'd32));
    script.push_back(cmd_row(CMD_PUT, NEWLINE_CODE, 4'd0, 8'h00, 1'b0, 1'b1, 1'b1, 32'h0));
    script.push_back(cfg_row(REG_BG_COLOR, 24'hABCDEF));
    script.push_back(cmd_row(CMD_PUT, NEWLINE_CODE, 4'd0, 8'h00, 1'b0, 1'b1, 1'b1,
                             32'hEFEFEFEF));
    // minimum width: each character wraps; then full width and a put while disabled
    script.push_back(cfg_row(REG_HEIGHT, 24'd4096));
    script.push_back(cfg_row(REG_WIDTH, 24'd16));
    script.push_back(cmd_row(CMD_PUT, 8'h55, 4'd0, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0));
    script.push_back(cfg_row(REG_FG_COLOR, 24'hFFFFFF));
    script.push_back(cfg_row(REG_BG_COLOR, 24'h000000));
    script.push_back(cfg_row(REG_ROW_PITCH, 24'd8192));
    script.push_back(cmd_row(CMD_PUT, 8'hFF, 4'd0, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0));
    script.push_back(cfg_row(REG_ROW_PITCH, 24'd16));
    script.push_back(cfg_row(REG_WIDTH, 24'd4096));
    script.push_back(cmd_row(CMD_PUT, 8'hAA, 4'd0, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0));
    script.push_back(cfg_row(REG_FG_COLOR, 24'h000000));
    script.push_back(cmd_row(CMD_PUT, 8'h00, 4'd0, 8'h00, 1'b1, 1'b0, 1'b0, 32'h0));
    script.push_back(cfg_row(REG_ENABLE, 24'd0));
    script.push_back(cmd_row(CMD_PUT, 8'hF0, 4'd0, 8'h00, 1'b0, 1'b1, 1'b0, 32'h0));
    script.push_back(cfg_row(REG_ENABLE, 24'd1));
    // character wrap that also clears the screen
    script.push_back(cfg_row(REG_FG_COLOR, 24'h123456));
    script.push_back(cfg_row(REG_BG_COLOR, 24'hFEDC99));
    script.push_back(cfg_row(REG_WIDTH, 24'd16));
    script.push_back(cfg_row(REG_HEIGHT, 24'd32));
    script.push_back(cmd_row(CMD_PUT, 8'h55, 4'd0, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0));
    script.push_back(cmd_row(CMD_PUT, 8'hAA, 4'd0, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // font rows for the glyphs drawn below
    for (int g = 0; g < PRELOAD_COUNT; g++) begin
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        issue_command(CMD_LOAD, PRELOAD_CODES[g], 4'(r), 8'($urandom), 1'($urandom),
                      1'b0, 1'b0, 32'h0);
      end
    end

    foreach (script[i]) begin
      if (script[i].what == STEP_CFG) begin
        write_register(script[i].reg_sel, script[i].value);
      end else begin
        issue_command(script[i].cmd, script[i].code, script[i].glyph_row, script[i].bits,
                      script[i].string_end, script[i].typed, script[i].typed_clear,
                      script[i].typed_fill);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      write_register(REG_ENABLE, 24'd1);
      write_register(REG_FG_COLOR, 24'($urandom));
      write_register(REG_BG_COLOR, 24'($urandom));
      write_register(REG_WIDTH, pick_span(16, 4096, 96));
      write_register(REG_HEIGHT, pick_span(32, 4096, 128));
      write_register(REG_ROW_PITCH, pick_span(16, 8192, 8192));
      calm_phase = (p == 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == PHASE_ITEMS / 2) hold_until_drained();
        roll = $urandom_range(0, 99);
        code = drawable_codes[$urandom_range(0, drawable_codes.size() - 1)];
        if (roll < 12) begin
          issue_command(CMD_LOAD, 8'($urandom), 4'($urandom), 8'($urandom), 1'($urandom),
                        1'b0, 1'b0, 32'h0);
        end else if (roll < 25) begin
          issue_command(CMD_LOAD, code, 4'($urandom), 8'($urandom), 1'($urandom),
                        1'b0, 1'b0, 32'h0);
        end else if (roll < 40) begin
          issue_command(CMD_PUT, NEWLINE_CODE, 4'($urandom), 8'($urandom), 1'($urandom),
                        1'b0, 1'b0, 32'h0);
        end else begin
          issue_command(CMD_PUT, code, 4'($urandom), 8'($urandom), 1'($urandom),
                        1'b0, 1'b0, 32'h0);
        end
      end
      calm_phase = 1'b0;
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
